// File: rtl/core/lzd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int WIN_AW = 12;

    localparam logic [WIN_AW:0]   WIN_SIZE   = 13'd4096;
    localparam logic [WIN_AW-1:0] REF_BIAS   = 12'h012;
    localparam logic [4:0]        LEN_BIAS   = 5'd3;
    localparam logic [3:0]        FLAG_COUNT = 4'd8;

    typedef struct packed {
        logic load_flags;
        logic shift_flags;
        logic load_ref_low;
        logic start_copy;
        logic emit_lit;
        logic emit_copy;
        logic emit_end;
        logic run_last;
        logic stream_end;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic flag_bit;
        logic cnt_last;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/lzd_if.sv
// ----------------------------------------------------------------------------
// LZSS decompressor channels
// Compressed byte channel and decompressed result channel, valid/ready.
// ----------------------------------------------------------------------------
interface lzd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;

    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

interface lzd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output data_byte, output data_valid,
                    output run_last, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input data_valid,
                    input run_last, input stream_end, output ready);
endinterface

// File: rtl/core/lzd_ctrl.sv
// ----------------------------------------------------------------------------
// LZSS decompressor controller
// Decodes the role of each incoming byte from the flag state and sequences
// reference copies one output byte per cycle while the output register is free.
// ----------------------------------------------------------------------------
module lzd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_byte,
    output logic          o_in_ready,
    input  lzd_pkg::t_stat i_stat,
    output lzd_pkg::t_cmd  o_cmd
);
    import lzd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_COPY = 1'b1;

    logic       r_state, n_state;
    logic [3:0] r_flags_left, n_flags_left;
    logic       r_await, n_await;
    logic       r_last, n_last;
    logic       acc;

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_flags_left = r_flags_left;
        n_await      = r_await;
        n_last       = r_last;
        o_in_ready   = (r_state == ST_IDLE) && i_stat.out_free;
        acc          = i_in_valid && o_in_ready;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (r_flags_left == 4'd0) begin
                        o_cmd.load_flags = 1'b1;
                        n_flags_left     = FLAG_COUNT;
                    end else if (i_stat.flag_bit) begin
                        o_cmd.emit_lit    = 1'b1;
                        o_cmd.run_last    = 1'b1;
                        o_cmd.shift_flags = 1'b1;
                        n_flags_left      = r_flags_left - 4'd1;
                    end else if (!r_await) begin
                        o_cmd.load_ref_low = 1'b1;
                        n_await            = 1'b1;
                    end else begin
                        o_cmd.start_copy  = 1'b1;
                        o_cmd.shift_flags = 1'b1;
                        n_flags_left      = r_flags_left - 4'd1;
                        n_await           = 1'b0;
                        n_last            = i_last_byte;
                        n_state           = ST_COPY;
                    end
                    // The last byte drops any pending flags or half reference.
                    if (i_last_byte) begin
                        n_flags_left = 4'd0;
                        n_await      = 1'b0;
                        if (!o_cmd.start_copy) begin
                            o_cmd.clear      = 1'b1;
                            o_cmd.stream_end = 1'b1;
                            o_cmd.run_last   = 1'b1;
                            if (!o_cmd.emit_lit) begin
                                o_cmd.emit_end = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_COPY: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_copy = 1'b1;
                    if (i_stat.cnt_last) begin
                        o_cmd.run_last   = 1'b1;
                        o_cmd.stream_end = r_last;
                        o_cmd.clear      = r_last;
                        n_state          = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_flags_left <= 4'd0;
            r_await      <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_flags_left <= n_flags_left;
            r_await      <= n_await;
            r_last       <= n_last;
        end
    end

endmodule

// File: rtl/core/lzd_dpath.sv
// ----------------------------------------------------------------------------
// LZSS decompressor datapath
// History window memory, write and source pointers, flag shifter and the
// registered output beat.
// ----------------------------------------------------------------------------
module lzd_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lzd_pkg::t_cmd  i_cmd,
    output lzd_pkg::t_stat o_stat,
    input  logic [7:0]     i_code_byte,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_data_byte,
    output logic           o_data_valid,
    output logic           o_run_last,
    output logic           o_stream_end
);
    import lzd_pkg::*;

    logic [7:0]        mem [WIN_SIZE];

    logic [WIN_AW-1:0] r_wp, n_wp;
    logic [WIN_AW:0]   r_bw, n_bw;
    logic [WIN_AW-1:0] r_src, n_src;
    logic [WIN_AW-1:0] r_dist;
    logic [4:0]        r_cnt;
    logic [7:0]        r_flags;
    logic [7:0]        r_ref_low;
    logic [7:0]        r_rd_data;
    logic              r_fwd_hit;
    logic [7:0]        r_fwd_data;

    logic              r_out_valid;
    logic [7:0]        r_data_byte;
    logic              r_data_valid;
    logic              r_run_last;
    logic              r_stream_end;

    logic [WIN_AW-1:0] ref_pos;
    logic [7:0]        src_byte;
    logic              src_ok;
    logic [7:0]        wr_data;
    logic              wr_en;
    logic              emit;

    assign ref_pos  = {i_code_byte[7:4], r_ref_low};
    // A write and a read of the same entry in one cycle: take the new byte.
    assign src_byte = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign src_ok   = (r_dist != '0) && (r_bw >= {1'b0, r_dist});
    assign wr_en    = i_cmd.emit_lit || i_cmd.emit_copy;
    assign wr_data  = i_cmd.emit_lit ? i_code_byte : (src_ok ? src_byte : 8'd0);
    assign emit     = wr_en || i_cmd.emit_end;

    always_comb begin
        n_src = r_src;
        if (i_cmd.start_copy) begin
            n_src = ref_pos + REF_BIAS;
        end else if (i_cmd.emit_copy) begin
            n_src = r_src + 1'b1;
        end
        n_wp = r_wp;
        n_bw = r_bw;
        if (wr_en) begin
            n_wp = r_wp + 1'b1;
            if (r_bw != WIN_SIZE) begin
                n_bw = r_bw + 1'b1;
            end
        end
        if (i_cmd.clear) begin
            n_wp = '0;
            n_bw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_wp] <= wr_data;
        end
        r_rd_data  <= mem[n_src];
        r_fwd_hit  <= wr_en && (r_wp == n_src);
        r_fwd_data <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        if (i_cmd.start_copy) begin
            r_dist <= r_wp - REF_BIAS - ref_pos;
            r_cnt  <= {1'b0, i_code_byte[3:0]} + LEN_BIAS;
        end else if (i_cmd.emit_copy) begin
            r_cnt <= r_cnt - 5'd1;
        end
        if (emit) begin
            // An end-only marker always carries a zero byte.
            r_data_byte  <= i_cmd.emit_end ? 8'd0 : wr_data;
            r_data_valid <= wr_en;
            r_run_last   <= i_cmd.run_last;
            r_stream_end <= i_cmd.stream_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_bw        <= '0;
            r_flags     <= '0;
            r_ref_low   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp <= n_wp;
            r_bw <= n_bw;
            if (i_cmd.clear) begin
                r_flags   <= '0;
                r_ref_low <= '0;
            end else begin
                if (i_cmd.load_flags) begin
                    r_flags <= i_code_byte;
                end else if (i_cmd.shift_flags) begin
                    r_flags <= {1'b0, r_flags[7:1]};
                end
                if (i_cmd.load_ref_low) begin
                    r_ref_low <= i_code_byte;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.flag_bit = r_flags[0];
    assign o_stat.cnt_last = (r_cnt == 5'd1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_data_byte  = r_data_byte;
    assign o_data_valid = r_data_valid;
    assign o_run_last   = r_run_last;
    assign o_stream_end = r_stream_end;

endmodule

// File: rtl/core/lzss_4k_window_decompressor.sv
// ----------------------------------------------------------------------------
// LZSS decompressor, 4 KiB window
// Top level: controller and datapath joined by command and status bundles.
// ----------------------------------------------------------------------------
// A flag byte, or the first byte of a reference, yields no result; a literal
// yields one result. The second byte of a reference starts a copy that then
// emits 3 to 18 bytes, one byte per cycle while the output register is free;
// the copy rate is set by the single write port and single read port of the
// 4096-byte history memory. Results leave through an output register, and a
// new byte is taken in the cycle the pending result is taken. There is no
// clearing pass after reset: window data is never used before it has been
// written in the current stream. The byte marked last ends the stream and
// returns all state to reset.
module lzss_4k_window_decompressor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lzd_in_if.sink         i_cmp,
    lzd_out_if.source      o_dec
);
    import lzd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lzd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmp.valid),
        .i_last_byte (i_cmp.last_byte),
        .o_in_ready  (i_cmp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lzd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_code_byte  (i_cmp.code_byte),
        .o_out_valid  (o_dec.valid),
        .i_out_ready  (o_dec.ready),
        .o_data_byte  (o_dec.data_byte),
        .o_data_valid (o_dec.data_valid),
        .o_run_last   (o_dec.run_last),
        .o_stream_end (o_dec.stream_end)
    );

endmodule

// File: rtl/core/lzd_checker.sv
// ----------------------------------------------------------------------------
// LZSS decompressor port checker
// Concurrent checks on the port behavior of the decompressor, bound to the
// top level.
// ----------------------------------------------------------------------------
module lzd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_data_byte,
    input logic       i_data_valid,
    input logic       i_run_last,
    input logic       i_stream_end
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte) &&
        $stable(i_data_valid) && $stable(i_run_last) && $stable(i_stream_end))
        else $error("result beat changed while stalled");

    // An end-only marker carries a zero byte and closes both the run and stream.
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_run_last && i_stream_end &&
        (i_data_byte == 8'd0))
        else $error("malformed end-only marker");

    // The end of a stream always closes the run that caused it.
    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stream_end |-> i_run_last)
        else $error("stream end without run end");

    // No byte is taken while a result sits unclaimed in the output register.
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while output stalled");

endmodule

bind lzss_4k_window_decompressor lzd_checker u_lzd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_cmp.ready),
    .i_out_valid  (o_dec.valid),
    .i_out_ready  (o_dec.ready),
    .i_data_byte  (o_dec.data_byte),
    .i_data_valid (o_dec.data_valid),
    .i_run_last   (o_dec.run_last),
    .i_stream_end (o_dec.stream_end)
);

// File: tb/sv/tb_lzss_4k_window_decompressor.sv
// ----------------------------------------------------------------------------
// LZSS 4 KiB window decompressor testbench
// Feeds compressed streams through the byte channel and checks every
// decompressed beat against an in-bench decoder: literals, overlapping and
// zero-filled copies, truncated streams, and throttled channels.
// ----------------------------------------------------------------------------
module tb_lzss_4k_window_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    import lzd_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } cmp_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       dv;
        logic       rl;
        logic       se;
    } dec_beat_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lzd_in_if  cmp_if ();
    lzd_out_if dec_if ();

    lzss_4k_window_decompressor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmp   (cmp_if),
        .o_dec   (dec_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stimulus and expectation stores.
    cmp_beat_t pend_q[$];
    dec_beat_t expect_q[$];
    int        queued;
    int        taken;
    int        src_idle_pct;
    int        snk_idle_pct;
    int        errors;
    int        beats_checked;
    int        streams_done;
    int        zero_fills;

    // Receiver hold-off, counted in its own process.
    logic      hold_arm;
    logic      hold_done;
    int        hold_left;

    // Decoder state mirrored from the block.
    logic [7:0]      hist [0:4095];
    logic [11:0]     wr_pos;
    logic [12:0]     produced;
    logic [7:0]      flag_sr;
    logic [3:0]      flags_left;
    logic [7:0]      ref_low;
    logic            await_hi;

    // Stream position as seen by the generator, used to aim references.
    logic [11:0]     gen_pos;
    logic [12:0]     gen_made;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        dec_beat_t beat;
        beat = '{data: b, dv: 1'b1, rl: 1'b0, se: 1'b0};
        expect_q.push_back(beat);
        hist[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
        if (produced < WIN_SIZE)
            produced = produced + 13'd1;
    endtask

    task automatic decode_byte(input logic [7:0] cb, input logic fin);
        logic [11:0] ref_pos;
        logic [11:0] back;
        logic [11:0] src;
        logic [4:0]  run_len;
        logic [7:0]  b;
        dec_beat_t   beat;
        int          n;
        int          j;
        n = 0;
        if (flags_left == 4'd0) begin
            flag_sr    = cb;
            flags_left = FLAG_COUNT;
        end else if (flag_sr[0]) begin
            emit_byte(cb);
            n          = 1;
            flag_sr    = flag_sr >> 1;
            flags_left = flags_left - 4'd1;
        end else if (!await_hi) begin
            ref_low  = cb;
            await_hi = 1'b1;
        end else begin
            ref_pos = {cb[7:4], ref_low};
            run_len = {1'b0, cb[3:0]} + LEN_BIAS;
            back    = wr_pos - REF_BIAS - ref_pos;
            for (j = 0; j < run_len; j++) begin
                b = 8'h00;
                // Sources before the stream start, and a zero distance, read as zero.
                if (back != 12'd0 && produced >= {1'b0, back}) begin
                    src = wr_pos - back;
                    b   = hist[src];
                end else begin
                    zero_fills++;
                end
                emit_byte(b);
                n++;
            end
            await_hi   = 1'b0;
            flag_sr    = flag_sr >> 1;
            flags_left = flags_left - 4'd1;
        end
        if (fin && n == 0) begin
            beat = '{data: 8'h00, dv: 1'b0, rl: 1'b0, se: 1'b0};
            expect_q.push_back(beat);
            n = 1;
        end
        if (n > 0) begin
            beat    = expect_q.pop_back();
            beat.rl = 1'b1;
            beat.se = fin;
            expect_q.push_back(beat);
        end
        if (fin) begin
            wr_pos     = '0;
            produced   = '0;
            flag_sr    = '0;
            flags_left = '0;
            ref_low    = '0;
            await_hi   = 1'b0;
            streams_done++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    task automatic push_item(input logic [7:0] cb, input logic fin);
        cmp_beat_t it;
        it.code = cb;
        it.fin  = fin;
        pend_q.push_back(it);
        queued++;
        if (fin) begin
            gen_pos  = '0;
            gen_made = '0;
        end
    endtask

    task automatic advance_gen(input int n);
        gen_pos  = gen_pos + 12'(n);
        gen_made = (gen_made + n > 4096) ? 13'd4096 : 13'(gen_made + n);
    endtask

    task automatic add_lit(input logic [7:0] b, input logic fin);
        advance_gen(1);
        push_item(b, fin);
    endtask

    task automatic add_ref_bytes(input logic [7:0] lo, input logic [7:0] hi,
                                 input logic fin);
        push_item(lo, 1'b0);
        advance_gen(int'(hi[3:0]) + 3);
        push_item(hi, fin);
    endtask

    task automatic add_ref_back(input logic [11:0] back, input logic [3:0] len_code,
                                input logic fin);
        logic [11:0] pos;
        pos = gen_pos - REF_BIAS - back;
        add_ref_bytes(pos[7:0], {pos[11:8], len_code}, fin);
    endtask

    // Mostly in-window distances, with zero, beyond-start and arbitrary ones mixed in.
    function automatic logic [11:0] pick_back();
        int r;
        int top;
        r = $urandom_range(0, 99);
        if (r < 70 && gen_made != 0) begin
            top = (gen_made > 4095) ? 4095 : int'(gen_made);
            return 12'($urandom_range(1, top));
        end
        if (r < 80)
            return 12'd0;
        if (r < 90 && gen_made < 4095)
            return 12'($urandom_range(int'(gen_made) + 1, 4095));
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic gen_stream();
        int         groups;
        int         ending;
        int         g;
        int         k;
        int         n;
        logic [7:0] flags;
        logic       fin;
        if ($urandom_range(0, 9) == 0) begin
            // Unstructured bytes, closed by a final beat.
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++)
                push_item(8'($urandom), k == n - 1);
        end else begin
            groups = $urandom_range(1, 3);
            ending = $urandom_range(0, 3);
            for (g = 0; g < groups; g++) begin
                flags = 8'($urandom);
                push_item(flags, 1'b0);
                for (k = 0; k < 8; k++) begin
                    fin = (ending == 0 && g == groups - 1 && k == 7);
                    if (flags[k])
                        add_lit(8'($urandom), fin);
                    else
                        add_ref_back(pick_back(), 4'($urandom), fin);
                end
            end
            case (ending)
                1: begin
                    push_item(8'($urandom), 1'b1);
                end
                2: begin
                    push_item(8'($urandom) & 8'hfe, 1'b0);
                    push_item(8'($urandom), 1'b1);
                end
                3: begin
                    push_item(8'($urandom) | 8'h01, 1'b0);
                    add_lit(8'($urandom), 1'b1);
                end
                default: ;
            endcase
        end
    endtask

    task automatic fill_streams(input int n_items);
        int target;
        target = queued + n_items;
        while (queued < target)
            gen_stream();
    endtask

    task automatic wait_drained();
        while (!(taken == queued && expect_q.size() == 0))
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cmp_beat_t nxt;
        if (!i_rst_n) begin
            cmp_if.valid     <= 1'b0;
            cmp_if.code_byte <= 8'h00;
            cmp_if.last_byte <= 1'b0;
        end else begin
            if (cmp_if.valid && cmp_if.ready) begin
                decode_byte(cmp_if.code_byte, cmp_if.last_byte);
                taken++;
            end
            if (cmp_if.valid && !cmp_if.ready) begin
                // Hold the offered beat until it is taken.
            end else if (pend_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = pend_q.pop_front();
                cmp_if.valid     <= 1'b1;
                cmp_if.code_byte <= nxt.code;
                cmp_if.last_byte <= nxt.fin;
            end else begin
                cmp_if.valid     <= 1'b0;
                cmp_if.code_byte <= 8'($urandom);
                cmp_if.last_byte <= 1'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dec_beat_t want;
        if (!i_rst_n) begin
            dec_if.ready <= 1'b0;
        end else begin
            if (dec_if.valid && dec_if.ready) begin
                beats_checked++;
                if (expect_q.size() == 0) begin
                    report_mismatch($sformatf("beat with nothing expected, data 0x%02h",
                                              dec_if.data_byte));
                end else begin
                    want = expect_q.pop_front();
                    if (dec_if.data_byte !== want.data)
                        report_mismatch($sformatf("data_byte 0x%02h, expected 0x%02h",
                                                  dec_if.data_byte, want.data));
                    if (dec_if.data_valid !== want.dv)
                        report_mismatch($sformatf("data_valid %b, expected %b",
                                                  dec_if.data_valid, want.dv));
                    if (dec_if.run_last !== want.rl)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  dec_if.run_last, want.rl));
                    if (dec_if.stream_end !== want.se)
                        report_mismatch($sformatf("stream_end %b, expected %b",
                                                  dec_if.stream_end, want.se));
                end
            end
            dec_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // One long hold-off of the receiver so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d beats still expected.", expect_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int         g;
        int         k;
        logic [7:0] flags;

        i_rst_n          = 1'b0;
        hold_arm         = 1'b0;
        src_idle_pct     = 34;
        snk_idle_pct     = 50;
        queued           = 0;
        taken            = 0;
        errors           = 0;
        beats_checked    = 0;
        streams_done     = 0;
        zero_fills       = 0;
        wr_pos           = '0;
        produced         = '0;
        flag_sr          = '0;
        flags_left       = '0;
        ref_low          = '0;
        await_hi         = 1'b0;
        gen_pos          = '0;
        gen_made         = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two literals at the byte extremes, then six references: an overlapping
        // run of maximum length, both window position extremes, a zero distance,
        // a source far before the stream start, and a source exactly at it.
        push_item(8'h03, 1'b0);
        add_lit(8'h00, 1'b0);
        add_lit(8'hff, 1'b0);
        add_ref_back(12'd1, 4'hf, 1'b0);
        add_ref_bytes(8'h00, 8'h00, 1'b0);
        add_ref_bytes(8'hff, 8'hff, 1'b0);
        add_ref_back(12'd0, 4'h2, 1'b0);
        add_ref_back(12'hfff, 4'h0, 1'b0);
        add_ref_back(gen_made[11:0], 4'h1, 1'b1);
        // A stream cut off at its flag byte gives only an end marker.
        push_item(8'h00, 1'b1);
        // A literal that closes its stream.
        push_item(8'h01, 1'b0);
        add_lit(8'h5a, 1'b1);
        // A stream cut off after the first byte of a reference.
        push_item(8'h00, 1'b0);
        push_item(8'h34, 1'b1);

        fill_streams(50);
        wait_drained();

        @(posedge i_clk);
        src_idle_pct <= 50;
        snk_idle_pct <= 34;
        fill_streams(50);
        wait_drained();

        @(posedge i_clk);
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        hold_arm     <= 1'b1;
        // One stream of mostly maximum-length copies, offered while the receiver holds off.
        for (g = 0; g < 4; g++) begin
            flags = 8'($urandom) & 8'($urandom) & 8'($urandom);
            push_item(flags, 1'b0);
            for (k = 0; k < 8; k++) begin
                if (flags[k])
                    add_lit(8'($urandom), g == 3 && k == 7);
                else
                    add_ref_back(pick_back(), 4'hf, g == 3 && k == 7);
            end
        end
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Decoded %0d compressed bytes in %0d streams; %0d beats checked.",
                 taken, streams_done, beats_checked);
        $display("%s %0d zero-filled copy bytes, truncated streams and a long output stall.",
                 "Runs included", zero_fills);
        if (errors == 0 && expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
